[src/assert_macros.svh]
// Assertion helpers for the RTL, included by timed_pulse_sequencer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define TPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define TPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/tps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed pulse sequencer package
// Field widths, command codes and table entry types.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 6;
  localparam int START_W  = 32;
  localparam int LENGTH_W = 16;
  localparam int CHAN_W   = 3;
  localparam int COUNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REWIND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  typedef struct packed {
    logic [START_W-1:0]  start;
    logic [LENGTH_W-1:0] length;
    logic [CHAN_W-1:0]   channel;
  } table_entry_t;

  typedef struct packed {
    logic [START_W-1:0] actual;
    logic               done;
  } pulse_status_t;

endpackage

[src/tps_interfaces.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed pulse sequencer channels
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tps_req_if;
  logic                          valid;
  logic                          ready;
  logic [tps_pkg::CMD_W-1:0]     command;
  logic [tps_pkg::INDEX_W-1:0]   entry_index;
  logic [tps_pkg::START_W-1:0]   entry_start;
  logic [tps_pkg::LENGTH_W-1:0]  entry_length;
  logic [tps_pkg::CHAN_W-1:0]    entry_channel;

  modport source (output valid, command, entry_index, entry_start, entry_length,
                  entry_channel, input ready);
  modport sink (input valid, command, entry_index, entry_start, entry_length,
                entry_channel, output ready);
endinterface

interface tps_rsp_if #(parameter int CHANNELS = 8);
  logic                         valid;
  logic                         ready;
  logic [CHANNELS-1:0]          channel_levels;
  logic                         busy_res;
  logic [tps_pkg::COUNT_W-1:0]  started_count;

  modport source (output valid, channel_levels, busy_res, started_count, input ready);
  modport sink (input valid, channel_levels, busy_res, started_count, output ready);
endinterface

interface tps_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tps_pkg::COUNT_W-1:0]  pulse_count;

  modport source (output valid, pulse_count, input ready);
  modport sink (input valid, pulse_count, output ready);
endinterface

[src/tps_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed pulse sequencer RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/timed_pulse_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed pulse sequencer
// Plays a loaded table of timed pulses onto a set of output channels.
// ----------------------------------------------------------------------------
// Usage:
//   req carries commands: load one table entry (and rewind), rewind, or one
//   millisecond tick. Every accepted item produces exactly one item on rsp
//   holding the channel levels, the busy flag and the started pulse count.
//   cfg writes pulse_count, the number of entries used for playback; it is
//   always ready and must only be written while the block is idle.
// Sequencing:
//   Load and rewind items go to ST_POST, which loads their result into the
//   output register once it is free. A tick walks entries 0 .. max(started,
//   min(pulse_count, TABLE_DEPTH))-1 through the table and status memories,
//   one entry per cycle with the read one entry ahead, then goes to ST_POST.
//   One item is in work at a time; req is ready only while no item is in work.
// Reset:
//   Synchronous reset clears playback state, levels and pulse_count. The
//   memories are not cleared; entries are meaningful once loaded.
// Stalls:
//   A result waits in the output register; the next item is accepted
//   meanwhile, and its result holds until the register is taken.
// ----------------------------------------------------------------------------
module timed_pulse_sequencer #(
  parameter int TABLE_DEPTH = 64,
  parameter int CHANNELS    = 8
) (
  input logic       clk,
  input logic       rst,
  tps_req_if.sink   req,
  tps_rsp_if.source rsp,
  tps_cfg_if.sink   cfg
);

  import tps_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;
  localparam logic [CHANNELS-1:0] CH_ONE = CHANNELS'(1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_POST  = 3'b100
  } state_t;

  state_t              state;
  logic [COUNT_W-1:0]  pulse_count;
  logic [NW-1:0]       np;
  logic [NW-1:0]       active;
  logic                running;
  logic [START_W-1:0]  elapsed;
  logic [CHANNELS-1:0] level_bits;
  logic                out_valid;
  logic [NW-1:0]       ridx;
  logic                rvalid;
  logic                alive;

  logic [NW-1:0]       eidx;
  logic [NW-1:0]       np_base;
  logic [NW-1:0]       bound;
  logic [CHANNELS-1:0] hmask;
  logic [CHANNELS-1:0] lmask;
  logic [CHANNELS-1:0] out_levels;
  logic                out_busy;
  logic [COUNT_W-1:0]  out_started;

  logic [NW-1:0]       used;
  logic                rd_en;
  logic                tbl_we;
  table_entry_t        tbl_wdata;
  table_entry_t        ent;
  pulse_status_t       sts;
  pulse_status_t       sts_wdata;
  logic                sts_we;
  logic [CHANNELS-1:0] ch_mask;
  logic                in_old;
  logic [START_W:0]    end_sum;
  logic                ends_old;
  logic                starts;
  logic                post_load;

  // Register values above the table depth act as the full table.
  always_comb begin
    if (CW'(pulse_count) > CW'(TABLE_DEPTH)) begin
      used = NW'(TABLE_DEPTH);
    end else begin
      used = NW'(pulse_count);
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign tbl_we = (state == ST_IDLE) && req.valid && (req.command == CMD_LOAD) &&
                  (32'(req.entry_index) < 32'(TABLE_DEPTH));
  assign tbl_wdata = '{start: req.entry_start, length: req.entry_length,
                       channel: req.entry_channel};

  assign rd_en = (state == ST_SWEEP) && (ridx < bound);

  tps_ram #(
    .WIDTH($bits(table_entry_t)),
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(AW'(req.entry_index)),
    .wdata(tbl_wdata),
    .re   (rd_en),
    .raddr(ridx[AW-1:0]),
    .rdata(ent)
  );

  // Status writes land on the entry just evaluated while the read runs one
  // entry ahead, so the walk never reads an entry it is still writing.
  tps_ram #(
    .WIDTH($bits(pulse_status_t)),
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_status (
    .clk  (clk),
    .we   (sts_we),
    .waddr(eidx[AW-1:0]),
    .wdata(sts_wdata),
    .re   (rd_en),
    .raddr(ridx[AW-1:0]),
    .rdata(sts)
  );

  // Entries below the old start count are checked for their end; the rest
  // start in order until the first one whose time has not yet come.
  always_comb begin
    if (32'(ent.channel) < 32'(CHANNELS)) begin
      ch_mask = CH_ONE << ent.channel;
    end else begin
      ch_mask = '0;
    end
    in_old   = eidx < np_base;
    end_sum  = {1'b0, sts.actual} + (START_W + 1)'(ent.length);
    ends_old = !sts.done && (end_sum <= {1'b0, elapsed});
    starts   = !in_old && alive && (eidx < used) && (ent.start <= elapsed);
    sts_we   = (state == ST_SWEEP) && rvalid && ((in_old && ends_old) || starts);
    if (starts) begin
      sts_wdata = '{actual: elapsed, done: (ent.length == '0)};
    end else begin
      sts_wdata = '{actual: sts.actual, done: 1'b1};
    end
  end

  assign post_load = (state == ST_POST) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pulse_count <= '0;
      np          <= '0;
      active      <= '0;
      running     <= 1'b0;
      elapsed     <= '0;
      level_bits  <= '0;
      out_valid   <= 1'b0;
      ridx        <= '0;
      rvalid      <= 1'b0;
      alive       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        pulse_count <= cfg.pulse_count;
      end

      if (post_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            case (req.command)
              CMD_LOAD, CMD_REWIND: begin
                np      <= '0;
                active  <= '0;
                running <= 1'b0;
                state   <= ST_POST;
              end
              CMD_TICK: begin
                running <= 1'b1;
                if (!running) begin
                  elapsed <= '0;
                end else if (elapsed != '1) begin
                  elapsed <= elapsed + 1'b1;
                end
                ridx   <= '0;
                rvalid <= 1'b0;
                alive  <= 1'b1;
                state  <= ST_SWEEP;
              end
              default: begin
                state <= ST_POST;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          rvalid <= rd_en;
          if (rd_en) begin
            ridx <= ridx + 1'b1;
          end
          if (rvalid) begin
            if (starts) begin
              np <= np + 1'b1;
              if (ent.length != '0) begin
                active <= active + 1'b1;
              end
            end else if (in_old && ends_old) begin
              active <= active - 1'b1;
            end
            if (!in_old && !starts) begin
              alive <= 1'b0;
            end
          end
          if (!rd_en && !rvalid) begin
            // Highs of this tick come first, then lows override them.
            level_bits <= (level_bits | hmask) & ~lmask;
            state      <= ST_POST;
          end
        end
        ST_POST: begin
          if (post_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && req.valid && (req.command == CMD_TICK)) begin
      np_base <= np;
      bound   <= (np > used) ? np : used;
      hmask   <= '0;
      lmask   <= '0;
    end else if ((state == ST_SWEEP) && rvalid) begin
      if (starts) begin
        hmask <= hmask | ch_mask;
        if (ent.length == '0) begin
          lmask <= lmask | ch_mask;
        end
      end else if (in_old && ends_old) begin
        lmask <= lmask | ch_mask;
      end
    end
    eidx <= ridx;
    if (post_load) begin
      out_levels  <= level_bits;
      out_busy    <= (np < used) || (active != '0);
      out_started <= COUNT_W'(np);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.channel_levels = out_levels;
  assign rsp.busy_res       = out_busy;
  assign rsp.started_count  = out_started;

  `TPS_ASSERT(a_active_le_started, (active <= np), "more active pulses than started")
  `TPS_ASSERT(a_walk_in_bound, (state == ST_SWEEP) |-> (ridx <= bound),
              "table walk ran past its bound")
  `TPS_ASSERT(a_post_delivers, post_load |=> rsp.valid,
              "finished result not presented")
  `TPS_ASSERT_ALWAYS(a_reset_clears, rst |=> (!rsp.valid && (state == ST_IDLE)),
                     "reset left a result or walk pending")

endmodule

[dv/timed_pulse_sequencer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed pulse sequencer testbench
// Drives load, rewind and tick items with random gaps and output stalls. It
// tracks its own copy of the pulse table and playback state, and checks every
// result item against the levels, busy flag and started count it predicts.
// ----------------------------------------------------------------------------
module timed_pulse_sequencer_test;
  import tps_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam int CHANNELS  = 8;
  localparam int RANDOM_ITEMS = 1300;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]    command;
    logic [INDEX_W-1:0]  entry_index;
    logic [START_W-1:0]  entry_start;
    logic [LENGTH_W-1:0] entry_length;
    logic [CHAN_W-1:0]   entry_channel;
  } tps_item_t;

  typedef struct {
    logic [CHANNELS-1:0] channel_levels;
    logic                busy_res;
    logic [COUNT_W-1:0]  started_count;
  } pulse_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tps_req_if                       req_ch ();
  tps_rsp_if #(.CHANNELS(CHANNELS)) rsp_ch ();
  tps_cfg_if                       cfg_ch ();

  timed_pulse_sequencer #(
    .TABLE_DEPTH(TBL_DEPTH),
    .CHANNELS(CHANNELS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted block state.
  table_entry_t        pulse_entries [TBL_DEPTH];
  pulse_status_t       pulse_state [TBL_DEPTH];
  int                  play_next;
  logic [START_W-1:0]  elapsed_ms;
  logic                playing;
  logic [CHANNELS-1:0] levels;
  logic [COUNT_W-1:0]  pulse_count;

  pulse_report_t expected_reports[$];
  int            mismatches = 0;
  int            items_sent = 0;
  bit            gaps_on = 1'b1;
  int            rsp_hold_left = 0;

  // Applies one accepted item to the predicted state and queues its report.
  task automatic predict_report(input tps_item_t it);
    int            used;
    int            i;
    logic [32:0]   end_ms;
    pulse_report_t rep;
    used = (pulse_count > TBL_DEPTH) ? TBL_DEPTH : int'(pulse_count);
    case (it.command)
      CMD_LOAD: begin
        pulse_entries[it.entry_index] = '{it.entry_start, it.entry_length, it.entry_channel};
        play_next = 0;
        playing = 1'b0;
      end
      CMD_REWIND: begin
        play_next = 0;
        playing = 1'b0;
      end
      CMD_TICK: begin
        if (!playing) begin
          playing = 1'b1;
          elapsed_ms = '0;
        end else if (elapsed_ms != '1) begin
          elapsed_ms = elapsed_ms + 1;
        end
        while (play_next < used && pulse_entries[play_next].start <= elapsed_ms) begin
          levels[pulse_entries[play_next].channel] = 1'b1;
          pulse_state[play_next] = '{elapsed_ms, 1'b0};
          play_next++;
        end
        // Ends are handled after starts, so a zero-length pulse ends low.
        for (i = 0; i < play_next; i++) begin
          end_ms = {1'b0, pulse_state[i].actual} + {17'b0, pulse_entries[i].length};
          if (!pulse_state[i].done && end_ms <= {1'b0, elapsed_ms}) begin
            levels[pulse_entries[i].channel] = 1'b0;
            pulse_state[i].done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    rep.channel_levels = levels;
    rep.busy_res = (play_next < used);
    for (i = 0; i < play_next; i++)
      if (!pulse_state[i].done) rep.busy_res = 1'b1;
    rep.started_count = play_next[COUNT_W-1:0];
    expected_reports.push_back(rep);
  endtask

  // Offers one item; valid stays high afterwards until the next item or idle.
  task automatic send_item(input tps_item_t it);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 25) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.command       <= it.command;
    req_ch.entry_index   <= it.entry_index;
    req_ch.entry_start   <= it.entry_start;
    req_ch.entry_length  <= it.entry_length;
    req_ch.entry_channel <= it.entry_channel;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_report(it);
    if (it.command != CMD_SPARE) items_sent++;
  endtask

  function automatic tps_item_t random_item(input logic [CMD_W-1:0] cmd);
    tps_item_t it;
    it.command       = cmd;
    it.entry_index   = INDEX_W'($urandom_range(TBL_DEPTH - 1));
    it.entry_start   = $urandom();
    it.entry_length  = LENGTH_W'($urandom_range(16'hFFFF));
    it.entry_channel = CHAN_W'($urandom_range(CHANNELS - 1));
    return it;
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] cmd);
    send_item(random_item(cmd));
  endtask

  task automatic send_load(input int idx, input logic [START_W-1:0] start,
                           input logic [LENGTH_W-1:0] len, input logic [CHAN_W-1:0] chan);
    tps_item_t it;
    it = random_item(CMD_LOAD);
    it.entry_index   = INDEX_W'(idx);
    it.entry_start   = start;
    it.entry_length  = len;
    it.entry_channel = chan;
    send_item(it);
  endtask

  // Loads one entry with content that mostly plays within a few dozen ticks.
  task automatic send_random_load(input int idx);
    logic [START_W-1:0]  start;
    logic [LENGTH_W-1:0] len;
    int                  pick;
    start = ($urandom_range(99) < 90) ? START_W'($urandom_range(30)) : $urandom();
    pick = $urandom_range(9);
    if (pick == 0) len = '0;
    else if (pick == 1) len = LENGTH_W'($urandom_range(16'hFFFF));
    else len = LENGTH_W'($urandom_range(15));
    send_load(idx, start, len, CHAN_W'($urandom_range(CHANNELS - 1)));
  endtask

  // Lowers valid and waits until every result item has come back.
  task automatic wait_idle;
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_pulse_count(input logic [COUNT_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.pulse_count <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    pulse_count = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_cmd(CMD_TICK);
  endtask

  // With no entries in use, ticks, rewinds and the spare code report idle.
  task automatic test_empty_table;
    write_pulse_count('0);
    send_ticks(2);
    send_cmd(CMD_SPARE);
    send_cmd(CMD_REWIND);
    send_cmd(CMD_TICK);
  endtask

  // Hand-built pulses: immediate start, zero length, longest length, a start
  // that never comes, and a rewind while a channel is still high.
  task automatic test_directed_pulses;
    send_load(0, '0, 16'd2, 3'd0);
    send_load(1, 32'd1, '0, 3'd7);
    send_load(2, 32'd3, 16'hFFFF, 3'd3);
    send_load(3, 32'hFFFF_FFFF, '0, 3'd5);
    send_load(63, 32'h5A5A_A5A5, 16'hA5A5, 3'd2);
    write_pulse_count(7'd4);
    send_ticks(6);
    send_cmd(CMD_REWIND);
    send_ticks(2);
    send_cmd(CMD_SPARE);
    send_cmd(CMD_TICK);
  endtask

  // Fills every entry back to back, then plays with counts past and at the end.
  task automatic test_full_table;
    int i;
    gaps_on = 1'b0;
    for (i = 0; i < TBL_DEPTH; i++) send_random_load(i);
    write_pulse_count('1);
    send_ticks(60);
    write_pulse_count(7'(TBL_DEPTH));
    send_cmd(CMD_REWIND);
    send_ticks(50);
    gaps_on = 1'b1;
  endtask

  // The receiver stops for a long stretch while ticks keep coming.
  task automatic test_output_backpressure;
    write_pulse_count(7'd8);
    send_cmd(CMD_REWIND);
    gaps_on = 1'b0;
    rsp_hold_left = 300;
    send_ticks(20);
    gaps_on = 1'b1;
  endtask

  // Episodes of a new count, a few reloads, then a run of ticks with some
  // rewinds and spare codes mixed in.
  task automatic test_random_playback;
    int pick;
    int span;
    int k;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(19);
      if (pick == 0) write_pulse_count('0);
      else if (pick == 1) write_pulse_count('1);
      else if (pick == 2) write_pulse_count(7'(TBL_DEPTH));
      else if (pick == 3) write_pulse_count(COUNT_W'($urandom_range(126, TBL_DEPTH + 1)));
      else write_pulse_count(COUNT_W'($urandom_range(12, 1)));
      span = (pulse_count == 0) ? TBL_DEPTH :
             (pulse_count > TBL_DEPTH) ? TBL_DEPTH : int'(pulse_count);
      repeat ($urandom_range(4)) send_random_load($urandom_range(span - 1));
      if ($urandom_range(3) == 0) send_cmd(CMD_REWIND);
      k = $urandom_range(60, 15);
      repeat (k) begin
        pick = $urandom_range(99);
        if (pick < 4) send_cmd(CMD_REWIND);
        else if (pick < 7) send_cmd(CMD_SPARE);
        else send_cmd(CMD_TICK);
      end
    end
  endtask

  always @(negedge clk) begin
    if (rsp_hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold_left = rsp_hold_left - 1;
    end else begin
      rsp_ch.ready <= !(gaps_on && $urandom_range(99) < 25);
    end
  end

  always @(posedge clk) begin : check_results
    pulse_report_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $error("result item with no expectation waiting");
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        if (rsp_ch.channel_levels !== want.channel_levels) begin
          $error("channel_levels: expected %h, actual %h",
                 want.channel_levels, rsp_ch.channel_levels);
          mismatches++;
        end
        if (rsp_ch.busy_res !== want.busy_res) begin
          $error("busy_res: expected %b, actual %b", want.busy_res, rsp_ch.busy_res);
          mismatches++;
        end
        if (rsp_ch.started_count !== want.started_count) begin
          $error("started_count: expected %0d, actual %0d",
                 want.started_count, rsp_ch.started_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    req_ch.valid         = 1'b0;
    req_ch.command       = CMD_REWIND;
    req_ch.entry_index   = '0;
    req_ch.entry_start   = '0;
    req_ch.entry_length  = '0;
    req_ch.entry_channel = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.pulse_count   = '0;
    rsp_ch.ready         = 1'b0;
    play_next   = 0;
    elapsed_ms  = '0;
    playing     = 1'b0;
    levels      = '0;
    pulse_count = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_directed_pulses();
    test_full_table();
    test_output_backpressure();
    test_random_playback();

    wait_idle();
    repeat (TBL_DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
